// ===== sv/utf8_xml_char_filter_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_xml_char_filter assertion macros
// shared property forms for the filter checks
// ----------------------------------------------------------------------------
`ifndef UTF8_XML_CHAR_FILTER_ASSERT_SVH
`define UTF8_XML_CHAR_FILTER_ASSERT_SVH

// same-cycle implication
`define UXF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UXF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/uxf_pkg.sv =====
// ----------------------------------------------------------------------------
// uxf_pkg
// types, constants and decode helpers shared by the utf-8 xml filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uxf_pkg;

	localparam logic [7:0] MASK_LEAD2 = 8'he0;
	localparam logic [7:0] CODE_LEAD2 = 8'hc0;
	localparam logic [7:0] MASK_LEAD3 = 8'hf0;
	localparam logic [7:0] CODE_LEAD3 = 8'he0;
	localparam logic [7:0] MASK_LEAD4 = 8'hf8;
	localparam logic [7:0] CODE_LEAD4 = 8'hf0;

	localparam logic [20:0] CP_TAB      = 21'h00009;
	localparam logic [20:0] CP_LF       = 21'h0000a;
	localparam logic [20:0] CP_CR       = 21'h0000d;
	localparam logic [20:0] CP_SPACE    = 21'h00020;
	localparam logic [20:0] CP_BMP1_HI  = 21'h0d7ff;
	localparam logic [20:0] CP_BMP2_LO  = 21'h0e000;
	localparam logic [20:0] CP_BMP2_HI  = 21'h0fffd;
	localparam logic [20:0] CP_SUPP_LO  = 21'h10000;
	localparam logic [20:0] CP_SUPP_HI  = 21'h10ffff;

	// one decoded sequence, or a bare end marker when count is zero
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            fin;
	} job_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		len = 3'd0;
		if (lead[7] == 1'b0)
			len = 3'd1;
		else if ((lead & MASK_LEAD2) == CODE_LEAD2)
			len = 3'd2;
		else if ((lead & MASK_LEAD3) == CODE_LEAD3)
			len = 3'd3;
		else if ((lead & MASK_LEAD4) == CODE_LEAD4)
			len = 3'd4;
		return len;
	endfunction

	function automatic logic xml_ok(input logic [20:0] cp);
		return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
			((cp >= CP_SPACE) && (cp <= CP_BMP1_HI)) ||
			((cp >= CP_BMP2_LO) && (cp <= CP_BMP2_HI)) ||
			((cp >= CP_SUPP_LO) && (cp <= CP_SUPP_HI));
	endfunction

endpackage

// ===== sv/uxf_front.sv =====
// ----------------------------------------------------------------------------
// uxf_front
// accepts raw bytes, tracks the pending sequence and emits decoded jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uxf_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   in_byte,
	input  logic         last,
	output logic         job_valid,
	output uxf_pkg::job_t job
);
	import uxf_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] p0_q, p1_q, p2_q;
	logic [1:0] cnt_d;
	logic       w0, w1, w2;
	logic [2:0] lead_len, byte_len;
	logic       cont, complete;
	logic [20:0] cp;

	assign lead_len = seq_len(p0_q);
	assign byte_len = seq_len(in_byte);
	assign cont     = (in_byte[7:6] == 2'b10);
	assign complete = (({1'b0, cnt_q} + 3'd1) >= lead_len);

	always_comb begin
		unique case (lead_len)
			3'd2:    cp = {10'd0, p0_q[4:0], in_byte[5:0]};
			3'd3:    cp = {5'd0, p0_q[3:0], p1_q[5:0], in_byte[5:0]};
			default: cp = {p0_q[2:0], p1_q[5:0], p2_q[5:0], in_byte[5:0]};
		endcase
	end

	always_comb begin
		job       = '0;
		job.fin   = last;
		cnt_d     = cnt_q;
		w0        = 1'b0;
		w1        = 1'b0;
		w2        = 1'b0;
		if (cnt_q != 2'd0 && cont) begin
			if (complete) begin
				job.bytes[0] = p0_q;
				job.bytes[1] = (lead_len == 3'd2) ? in_byte : p1_q;
				job.bytes[2] = (lead_len == 3'd3) ? in_byte : p2_q;
				job.bytes[3] = in_byte;
				job.count    = xml_ok(cp) ? lead_len : 3'd0;
				cnt_d        = 2'd0;
			end else begin
				w1    = (cnt_q == 2'd1);
				w2    = (cnt_q == 2'd2);
				cnt_d = cnt_q + 2'd1;
			end
		end else begin
			cnt_d = 2'd0;
			if (byte_len == 3'd1) begin
				job.bytes[0] = in_byte;
				job.count    = xml_ok({13'd0, in_byte}) ? 3'd1 : 3'd0;
			end else if (byte_len != 3'd0) begin
				w0    = 1'b1;
				cnt_d = 2'd1;
			end
		end
		if (last)
			cnt_d = 2'd0;
		job_valid = take && (last || job.count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && w0)
			p0_q <= in_byte;
		if (take && w1)
			p1_q <= in_byte;
		if (take && w2)
			p2_q <= in_byte;
	end

endmodule

// ===== sv/uxf_queue.sv =====
// ----------------------------------------------------------------------------
// uxf_queue
// small job queue between the decoder and the serializer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uxf_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  uxf_pkg::job_t wr_data,
	input  logic          rd,
	output uxf_pkg::job_t rd_data,
	output logic          full,
	output logic          empty
);
	import uxf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (do_rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== sv/uxf_back.sv =====
// ----------------------------------------------------------------------------
// uxf_back
// serializes queued jobs into one result item per cycle while the output register is not held
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uxf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  uxf_pkg::job_t q_data,
	output logic          q_rd,
	output logic          busy,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          has_byte,
	output logic          run_last,
	output logic          stream_end
);
	import uxf_pkg::*;

	job_t       work_q;
	logic       work_vld_q;
	logic [1:0] idx_q;
	logic       out_vld_q;
	logic [7:0] byte_q;
	logic       has_q, rlast_q, send_q;
	logic       advance, w_has, w_last;

	assign w_has   = (work_q.count != 3'd0);
	assign w_last  = !w_has || (({1'b0, idx_q} + 3'd1) == work_q.count);
	assign advance = work_vld_q && (!out_vld_q || pop);
	assign q_rd    = !q_empty && (!work_vld_q || (advance && w_last));
	assign busy    = work_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_vld_q <= 1'b0;
			idx_q      <= 2'd0;
			out_vld_q  <= 1'b0;
		end else begin
			if (q_rd) begin
				work_vld_q <= 1'b1;
				idx_q      <= 2'd0;
			end else if (advance) begin
				if (w_last)
					work_vld_q <= 1'b0;
				else
					idx_q <= idx_q + 2'd1;
			end
			if (advance)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			work_q <= q_data;
		if (advance) begin
			byte_q  <= w_has ? work_q.bytes[idx_q] : 8'd0;
			has_q   <= w_has;
			rlast_q <= w_last;
			send_q  <= w_last && work_q.fin;
		end
	end

	assign empty      = !out_vld_q;
	assign out_byte   = byte_q;
	assign has_byte   = has_q;
	assign run_last   = rlast_q;
	assign stream_end = send_q;

endmodule

// ===== sv/utf8_xml_char_filter.sv =====
// ----------------------------------------------------------------------------
// utf8_xml_char_filter
// utf-8 byte filter that keeps only characters allowed in xml 1.0
// ----------------------------------------------------------------------------
// channel  ports                                  handshake
// input    in_byte, last                          push / full
// result   out_byte, has_byte, run_last,          pop / empty
//          stream_end
//
// one input item per cycle while full is low; a kept sequence of n bytes
// leaves as n items, one per cycle while the output register is not held,
// from the serializer through the job queue, work and output registers
// full rises when QUEUE_DEPTH jobs wait; empty follows the output register
// reset clears the pending count, queue pointers and output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_xml_char_filter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       last,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       stream_end
);
	import uxf_pkg::*;

	logic take;
	logic job_vld;
	job_t job, q_data;
	logic q_full, q_empty, q_rd, back_busy;

	assign full = q_full;
	assign take = push && !q_full;

	uxf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.last      (last),
		.job_valid (job_vld),
		.job       (job)
	);

	uxf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_vld),
		.wr_data (job),
		.rd      (q_rd),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	uxf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.busy       (back_busy),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_last   (run_last),
		.stream_end (stream_end)
	);

`include "utf8_xml_char_filter_assert.svh"

	`UXF_ASSERT_NOW(a_end_is_run_last, !empty && stream_end, run_last, "stream_end without run_last")
	`UXF_ASSERT_NOW(a_bare_marker, !empty && !has_byte, stream_end && run_last && out_byte == 8'd0, "bad bare end marker")
	`UXF_ASSERT_NEXT(a_last_leaves_work, take && last, !empty || back_busy || !q_empty, "end of string lost")

endmodule
